@@ rtl/rc4_pkg.sv @@
// shared constants for the rc4 stream cipher core
// register indexes, operation codes and table sizes; no dependencies
package rc4_pkg;

  // table geometry
  localparam int unsigned TableDepth  = 256;
  localparam int unsigned AddrW       = $clog2(TableDepth);
  localparam int unsigned ByteW       = 8;

  // key storage
  localparam int unsigned MaxKeyBytes = 32;
  localparam int unsigned KeyWordW    = 64;
  localparam int unsigned KeyWords    = 4;
  localparam int unsigned KeyIdxW     = $clog2(MaxKeyBytes);
  localparam int unsigned KeyLenW     = 6;

  // configuration port
  localparam int unsigned CfgAddrW    = 3;

  localparam logic [CfgAddrW-1:0] RegKeyWord0 = 3'd0;
  localparam logic [CfgAddrW-1:0] RegKeyWord1 = 3'd1;
  localparam logic [CfgAddrW-1:0] RegKeyWord2 = 3'd2;
  localparam logic [CfgAddrW-1:0] RegKeyWord3 = 3'd3;
  localparam logic [CfgAddrW-1:0] RegKeyLength = 3'd4;

  localparam logic [KeyLenW-1:0] KeyLenReset = 6'd16;

  // operation codes carried in tuser
  localparam logic OpStart = 1'b0;
  localparam logic OpData  = 1'b1;

endpackage

@@ rtl/rc4_sbox_ram.sv @@
// permutation table storage: one write port, one registered read port
// per-entry valid bits make unwritten entries read as their own index; uses rc4_pkg
module rc4_sbox_ram (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       clr_i,
  input  logic                       we_i,
  input  logic [rc4_pkg::AddrW-1:0]  waddr_i,
  input  logic [rc4_pkg::ByteW-1:0]  wdata_i,
  input  logic                       re_i,
  input  logic [rc4_pkg::AddrW-1:0]  raddr_i,
  output logic [rc4_pkg::ByteW-1:0]  rdata_o
);
  import rc4_pkg::*;

  logic [ByteW-1:0]      mem [TableDepth];
  logic [TableDepth-1:0] vld_q;
  logic [ByteW-1:0]      mem_rd_q;
  logic                  vld_rd_q;
  logic [AddrW-1:0]      raddr_q;

  // storage array and read data register
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      mem_rd_q <= mem[raddr_i];
      raddr_q  <= raddr_i;
    end
  end

  // valid bits: cleared by reset or by a restart of the table
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      vld_rd_q <= 1'b0;
    end else begin
      if (re_i) begin
        vld_rd_q <= vld_q[raddr_i] & ~clr_i;
      end
      if (clr_i) begin
        vld_q <= '0;
      end else if (we_i) begin
        vld_q[waddr_i] <= 1'b1;
      end
    end
  end

  // unwritten entries hold the identity value
  assign rdata_o = vld_rd_q ? mem_rd_q : raddr_q;

endmodule

@@ rtl/rc4_stream_cipher_core.sv @@
// rc4 stream cipher core: key schedule and keystream generation
// depends on rc4_pkg and rc4_sbox_ram
//
// channel   dir  handshake               payload
// s_axis    in   tvalid/tready           tdata[7:0] data_in, tuser operation
// m_axis    out  tvalid/tready           tdata[7:0] data_out
// cfg       in   cfg_we_i                cfg_addr_i index, cfg_wdata_i value
//
// a data beat makes dependent reads of S[i], S[j] and S[S[i]+S[j]]
// through the single read port of the table, plus the second swap write.
// a start beat clears the table and then runs one key schedule step per entry; each step is a read,
// a read, and two writes on the same table port pair.
// reset is immediate: valid bits make the table read as identity; no sweep.
// a held output beat stalls the engine only when the next result is ready.
module rc4_stream_cipher_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration writes
  input  logic                          cfg_we_i,
  input  logic [rc4_pkg::CfgAddrW-1:0]  cfg_addr_i,
  input  logic [rc4_pkg::KeyWordW-1:0]  cfg_wdata_i,
  // input stream
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [7:0]                    s_axis_tdata,   // [7:0] data_in
  input  logic                          s_axis_tuser,   // [0] operation
  // output stream
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [7:0]                    m_axis_tdata    // [7:0] data_out
);
  import rc4_pkg::*;

  typedef enum logic [2:0] {
    StIdle,
    StGenJ,
    StGenT,
    StGenOut,
    StKsReadM,
    StKsReadJ,
    StKsWriteM,
    StKsWriteJ
  } state_e;

  state_e state_q;

  logic [KeyWordW-1:0] key_q [KeyWords];
  logic [KeyLenW-1:0]  key_len_q;

  logic [AddrW-1:0] i_q, j_q, t_q, m_q;
  logic [ByteW-1:0] si_q, sj_q, din_q;
  logic [KeyIdxW-1:0] kidx_q;
  logic [ByteW-1:0] out_data_q;
  logic             out_valid_q;

  // table port
  logic             tbl_clr, tbl_we, tbl_re;
  logic [AddrW-1:0] tbl_waddr, tbl_raddr;
  logic [ByteW-1:0] tbl_wdata, tbl_rdata;

  logic             in_beat, out_beat, out_free;
  logic [KeyLenW-1:0] klen_eff;
  logic [KeyLenW-1:0] kidx_next;
  logic [KeyWords*KeyWordW-1:0] key_flat;
  logic [ByteW-1:0] key_byte;
  logic [AddrW-1:0] gen_j, gen_t, ks_j;
  logic [ByteW-1:0] ks_byte;

  assign in_beat  = s_axis_tvalid && s_axis_tready;
  assign out_beat = m_axis_tvalid && m_axis_tready;
  assign out_free = !out_valid_q || m_axis_tready;

  assign s_axis_tready = (state_q == StIdle);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // effective key length, saturated to 1..MaxKeyBytes
  always_comb begin
    if (key_len_q == '0) begin
      klen_eff = KeyLenW'(1);
    end else if (key_len_q > KeyLenW'(MaxKeyBytes)) begin
      klen_eff = KeyLenW'(MaxKeyBytes);
    end else begin
      klen_eff = key_len_q;
    end
  end

  assign kidx_next = KeyLenW'(kidx_q) + KeyLenW'(1);
  assign key_flat  = {key_q[3], key_q[2], key_q[1], key_q[0]};
  assign key_byte  = key_flat[{kidx_q, 3'b000} +: ByteW];

  // index arithmetic, mod 256 by width
  assign gen_j = j_q + tbl_rdata;
  assign gen_t = si_q + tbl_rdata;
  assign ks_j  = j_q + tbl_rdata + key_byte;

  // keystream byte: forward the swapped pair over the table read
  always_comb begin
    if (t_q == j_q) begin
      ks_byte = si_q;
    end else if (t_q == i_q) begin
      ks_byte = sj_q;
    end else begin
      ks_byte = tbl_rdata;
    end
  end

  // table port control
  always_comb begin
    tbl_clr   = 1'b0;
    tbl_we    = 1'b0;
    tbl_waddr = i_q;
    tbl_wdata = tbl_rdata;
    tbl_re    = 1'b0;
    tbl_raddr = i_q + AddrW'(1);
    unique case (state_q)
      StIdle: begin
        if (in_beat) begin
          if (s_axis_tuser == OpStart) begin
            tbl_clr = 1'b1;
          end else begin
            tbl_re = 1'b1;
          end
        end
      end
      StGenJ: begin
        tbl_re    = 1'b1;
        tbl_raddr = gen_j;
      end
      StGenT: begin
        tbl_we    = 1'b1;
        tbl_waddr = i_q;
        tbl_wdata = tbl_rdata;
        tbl_re    = 1'b1;
        tbl_raddr = gen_t;
      end
      StGenOut: begin
        tbl_we    = 1'b1;
        tbl_waddr = j_q;
        tbl_wdata = si_q;
      end
      StKsReadM: begin
        tbl_re    = 1'b1;
        tbl_raddr = m_q;
      end
      StKsReadJ: begin
        tbl_re    = 1'b1;
        tbl_raddr = ks_j;
      end
      StKsWriteM: begin
        tbl_we    = 1'b1;
        tbl_waddr = m_q;
        tbl_wdata = tbl_rdata;
      end
      StKsWriteJ: begin
        tbl_we    = 1'b1;
        tbl_waddr = j_q;
        tbl_wdata = si_q;
      end
      default: begin
        tbl_we = 1'b0;
      end
    endcase
  end

  rc4_sbox_ram u_sbox (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .clr_i   (tbl_clr),
    .we_i    (tbl_we),
    .waddr_i (tbl_waddr),
    .wdata_i (tbl_wdata),
    .re_i    (tbl_re),
    .raddr_i (tbl_raddr),
    .rdata_o (tbl_rdata)
  );

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int w = 0; w < KeyWords; w++) begin
        key_q[w] <= '0;
      end
      key_len_q <= KeyLenReset;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        RegKeyWord0:  key_q[0]  <= cfg_wdata_i;
        RegKeyWord1:  key_q[1]  <= cfg_wdata_i;
        RegKeyWord2:  key_q[2]  <= cfg_wdata_i;
        RegKeyWord3:  key_q[3]  <= cfg_wdata_i;
        RegKeyLength: key_len_q <= cfg_wdata_i[KeyLenW-1:0];
        default: begin
          key_len_q <= key_len_q;
        end
      endcase
    end
  end

  // sequencer with indices and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      i_q         <= '0;
      j_q         <= '0;
      t_q         <= '0;
      m_q         <= '0;
      si_q        <= '0;
      sj_q        <= '0;
      din_q       <= '0;
      kidx_q      <= '0;
      out_data_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_beat) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        StIdle: begin
          if (in_beat) begin
            if (s_axis_tuser == OpStart) begin
              m_q     <= '0;
              j_q     <= '0;
              kidx_q  <= '0;
              state_q <= StKsReadM;
            end else begin
              i_q     <= i_q + AddrW'(1);
              din_q   <= s_axis_tdata;
              state_q <= StGenJ;
            end
          end
        end
        StGenJ: begin
          si_q    <= tbl_rdata;
          j_q     <= gen_j;
          state_q <= StGenT;
        end
        StGenT: begin
          sj_q    <= tbl_rdata;
          t_q     <= gen_t;
          state_q <= StGenOut;
        end
        StGenOut: begin
          if (out_free) begin
            out_data_q  <= din_q ^ ks_byte;
            out_valid_q <= 1'b1;
            state_q     <= StIdle;
          end
        end
        StKsReadM: begin
          state_q <= StKsReadJ;
        end
        StKsReadJ: begin
          si_q    <= tbl_rdata;
          j_q     <= ks_j;
          state_q <= StKsWriteM;
        end
        StKsWriteM: begin
          state_q <= StKsWriteJ;
        end
        StKsWriteJ: begin
          if (kidx_next >= klen_eff) begin
            kidx_q <= '0;
          end else begin
            kidx_q <= kidx_next[KeyIdxW-1:0];
          end
          if (m_q == AddrW'(TableDepth - 1)) begin
            i_q     <= '0;
            j_q     <= '0;
            state_q <= StIdle;
          end else begin
            m_q     <= m_q + AddrW'(1);
            state_q <= StKsReadM;
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

  // key schedule leaves both indices cleared
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StKsWriteJ && m_q == AddrW'(TableDepth - 1)) |=>
      (i_q == '0 && j_q == '0 && state_q == StIdle))
    else $error("indices not cleared after key schedule");

  // a held result stalls the final step of generation
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StGenOut && out_valid_q && !m_axis_tready) |=>
      (state_q == StGenOut))
    else $error("generation finished over a held result");

  // a start beat never produces a result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_beat && s_axis_tuser == OpStart) |=> !$rose(out_valid_q))
    else $error("result raised by a start beat");

  // table is written only during generation or key schedule
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    tbl_we |-> (state_q != StIdle && state_q != StGenJ &&
                state_q != StKsReadM && state_q != StKsReadJ))
    else $error("table written outside a write step");

endmodule

@@ sim/tb.sv @@
`timescale 1ns / 1ps
// self-checking testbench for rc4_stream_cipher_core
// depends on rc4_pkg and the core; keeps its own rc4 state to predict each output byte
module tb;
  import rc4_pkg::*;

  localparam int unsigned SettleCycles = 1100;
  localparam int unsigned RandomItems  = 1000;
  localparam int unsigned GapMax       = 17;
  localparam int unsigned ErrPrintMax  = 50;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                cfg_we_i      = 1'b0;
  logic [CfgAddrW-1:0] cfg_addr_i    = '0;
  logic [KeyWordW-1:0] cfg_wdata_i   = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [7:0]          s_axis_tdata  = '0;  // [7:0] data_in
  logic                s_axis_tuser  = 1'b0;  // [0] operation
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [7:0]          m_axis_tdata;  // [7:0] data_out

  rc4_stream_cipher_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // cipher state as the testbench sees it
  logic [ByteW-1:0]    sbox_q [TableDepth];
  logic [ByteW-1:0]    gen_i;
  logic [ByteW-1:0]    gen_j;
  logic [KeyWordW-1:0] key_words [KeyWords];
  logic [KeyLenW-1:0]  key_len_q;

  logic [7:0] cipher_bytes [$];
  logic [7:0] want_byte;

  int unsigned idle_odds     = 0;  // percent chance of an idle burst per beat
  int unsigned err_count     = 0;
  int unsigned starts_sent   = 0;
  int unsigned bytes_sent    = 0;
  int unsigned bytes_checked = 0;
  int unsigned key_settings  = 0;

  // clock
  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // reset state of the cipher
  initial begin
    for (int n = 0; n < TableDepth; n++) sbox_q[n] = ByteW'(n);
    gen_i = '0;
    gen_j = '0;
    for (int w = 0; w < KeyWords; w++) key_words[w] = '0;
    key_len_q = KeyLenReset;
  end

  function automatic void swap_sbox(logic [ByteW-1:0] a, logic [ByteW-1:0] b);
    logic [ByteW-1:0] tmp;
    tmp       = sbox_q[a];
    sbox_q[a] = sbox_q[b];
    sbox_q[b] = tmp;
  endfunction

  // key schedule over a fresh identity table, key length clamped to 1..MaxKeyBytes
  function automatic void schedule_key();
    int unsigned      len;
    logic [ByteW-1:0] acc;
    logic [KeyIdxW-1:0] kidx;
    logic [ByteW-1:0] kbyte;
    len = key_len_q;
    if (len == 0) len = 1;
    if (len > MaxKeyBytes) len = MaxKeyBytes;
    acc = '0;
    for (int n = 0; n < TableDepth; n++) sbox_q[n] = ByteW'(n);
    for (int m = 0; m < TableDepth; m++) begin
      kidx  = KeyIdxW'(m % len);
      kbyte = key_words[kidx[4:3]][kidx[2:0]*8 +: 8];
      acc   = acc + sbox_q[m] + kbyte;
      swap_sbox(ByteW'(m), acc);
    end
    gen_i = '0;
    gen_j = '0;
  endfunction

  // one generation step, returns the keystream byte
  function automatic logic [ByteW-1:0] next_keystream();
    logic [ByteW-1:0] pick;
    gen_i = gen_i + 1'b1;
    gen_j = gen_j + sbox_q[gen_i];
    swap_sbox(gen_i, gen_j);
    pick = sbox_q[gen_i] + sbox_q[gen_j];
    return sbox_q[pick];
  endfunction

  // register write; only called while the core is idle
  task automatic write_reg(input logic [CfgAddrW-1:0] addr, input logic [KeyWordW-1:0] value);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= addr;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (addr < KeyWords) begin
      key_words[addr] = value;
    end else if (addr == RegKeyLength) begin
      key_len_q = value[KeyLenW-1:0];
    end
  endtask

  // send one beat and predict its effect once accepted
  task automatic send_beat(input logic op, input logic [7:0] din);
    @(negedge clk_i);
    if (idle_odds != 0 && $urandom_range(1, 100) <= idle_odds) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, GapMax)) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= din;
    do @(posedge clk_i); while (!s_axis_tready);
    if (op == OpStart) begin
      schedule_key();
      starts_sent++;
    end else begin
      cipher_bytes.push_back(din ^ next_keystream());
      bytes_sent++;
    end
  endtask

  // stop sending, wait for every output byte, then let a key schedule finish
  task automatic settle();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (cipher_bytes.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // output side stalls
  always begin
    @(negedge clk_i);
    if (idle_odds != 0 && $urandom_range(1, 100) <= idle_odds) begin
      m_axis_tready <= 1'b0;
      repeat ($urandom_range(1, GapMax)) @(negedge clk_i);
    end
    m_axis_tready <= 1'b1;
  end

  // compare each output beat with the oldest predicted byte
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (cipher_bytes.size() == 0) begin
        err_count++;
        if (err_count <= ErrPrintMax)
          $error("data_out: expected nothing, actual %02h", m_axis_tdata);
      end else begin
        want_byte = cipher_bytes.pop_front();
        bytes_checked++;
        if (m_axis_tdata !== want_byte) begin
          err_count++;
          if (err_count <= ErrPrintMax)
            $error("data_out: expected %02h, actual %02h", want_byte, m_axis_tdata);
        end
      end
    end
  end

  // data right after reset runs on the identity table
  task automatic test_data_before_start();
    idle_odds = 0;
    send_beat(OpData, 8'h00);
    send_beat(OpData, 8'hFF);
    send_beat(OpData, 8'hA5);
    send_beat(OpData, 8'h5A);
    send_beat(OpData, 8'($urandom));
    settle();
  endtask

  // all key registers, writes to unused indexes, then one short message
  task automatic test_key_registers();
    idle_odds = 30;
    write_reg(RegKeyWord0, 64'h0706_0504_0302_0100);
    write_reg(RegKeyWord1, 64'h0F0E_0D0C_0B0A_0908);
    write_reg(RegKeyWord2, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(RegKeyWord3, 64'h8040_2010_0804_0201);
    write_reg(RegKeyLength, 64'd5);
    for (int a = RegKeyLength + 1; a < (1 << CfgAddrW); a++)
      write_reg(CfgAddrW'(a), '1);
    key_settings++;
    send_beat(OpStart, 8'hFF);
    repeat (4) send_beat(OpData, 8'($urandom));
    settle();
  endtask

  // zero length, length above the maximum, and both legal extremes
  task automatic test_key_length_limits();
    logic [KeyLenW-1:0] lens [4];
    lens[0] = '0;
    lens[1] = '1;
    lens[2] = KeyLenW'(1);
    lens[3] = KeyLenW'(MaxKeyBytes);
    idle_odds = 10;
    foreach (lens[k]) begin
      write_reg(RegKeyLength, KeyWordW'(lens[k]));
      key_settings++;
      send_beat(OpStart, 8'($urandom));
      send_beat(OpData, 8'($urandom));
      settle();
    end
  endtask

  // a new key must not disturb the running stream until the next start
  task automatic test_key_change_after_start();
    idle_odds = 0;
    send_beat(OpStart, 8'h00);
    send_beat(OpData, 8'h3C);
    settle();
    for (int w = 0; w < KeyWords; w++)
      write_reg(CfgAddrW'(w), {$urandom, $urandom});
    key_settings++;
    send_beat(OpData, 8'hC3);
    send_beat(OpData, 8'($urandom));
    settle();
    send_beat(OpStart, 8'h00);
    send_beat(OpData, 8'($urandom));
    settle();
  endtask

  // random keys and messages, some streams continued without a start
  task automatic test_random_traffic();
    int unsigned sent;
    int unsigned msg_len;
    int unsigned noise_len;
    logic [KeyWordW-1:0] wval;
    sent = 0;
    while (sent < RandomItems) begin
      settle();
      if (sent >= RandomItems * 3 / 4) begin
        idle_odds = 0;
      end else begin
        case ($urandom_range(0, 2))
          0:       idle_odds = 0;
          1:       idle_odds = 10;
          default: idle_odds = 35;
        endcase
      end

      // new key material while idle
      for (int w = 0; w < KeyWords; w++) begin
        if ($urandom_range(0, 1) == 1) begin
          case ($urandom_range(0, 5))
            0:       wval = '0;
            1:       wval = '1;
            default: wval = {$urandom, $urandom};
          endcase
          write_reg(CfgAddrW'(w), wval);
        end
      end
      if ($urandom_range(0, 2) != 0) begin
        case ($urandom_range(0, 9))
          0:       wval = '0;
          1:       wval = KeyWordW'($urandom_range(MaxKeyBytes + 1, (1 << KeyLenW) - 1));
          default: wval = KeyWordW'($urandom_range(1, MaxKeyBytes));
        endcase
        write_reg(RegKeyLength, wval);
      end
      if ($urandom_range(0, 5) == 0)
        write_reg(CfgAddrW'($urandom_range(RegKeyLength + 1, (1 << CfgAddrW) - 1)),
                  {$urandom, $urandom});
      key_settings++;

      // old stream carried on before the new start
      if ($urandom_range(0, 7) == 0) begin
        noise_len = $urandom_range(1, 6);
        repeat (noise_len) send_beat(OpData, 8'($urandom));
        sent += noise_len;
      end

      repeat ($urandom_range(1, 2)) begin
        send_beat(OpStart, 8'($urandom));
        // long streams let the index wrap past the table end
        if (sent == 0 || $urandom_range(0, 9) == 0)
          msg_len = $urandom_range(200, 320);
        else
          msg_len = $urandom_range(4, 60);
        repeat (msg_len) send_beat(OpData, 8'($urandom));
        sent += msg_len + 1;
      end
    end
    settle();
  endtask

  // main sequence
  initial begin
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_data_before_start();
    test_key_registers();
    test_key_length_limits();
    test_key_change_after_start();
    test_random_traffic();
    $display("ran %0d key schedules under %0d key settings, %0d data bytes sent",
             starts_sent, key_settings, bytes_sent);
    $display("compared %0d output bytes, %0d errors", bytes_checked, err_count);
    if (err_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // watchdog
  initial begin
    #8_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
